// ===== sv/tkd_pkg.sv =====
package tkd_pkg;

    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int PERCENT_SCALE_DEF = 100;

    localparam int RAW_W      = 8;
    localparam int RAW_SHIFT  = 3;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PCT_W      = 8;
    localparam int KEY_W      = 8;
    localparam int KEY_DIM    = 4;
    localparam int KEY_ROW_STEP = 25;
    localparam int KEY_COL_STEP = 33;
    localparam int OUT_W      = 48;

    localparam logic [CFG_W-1:0] CAL_LOW_RST   = 8'd0;
    localparam logic [CFG_W-1:0] CAL_HIGH_RST  = 8'd255;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd10;

    localparam logic [PCT_W-1:0] PCT_POS_LIMIT = 8'h7F;
    localparam logic [PCT_W-1:0] PCT_NEG_LIMIT = 8'h80;
    localparam logic [KEY_W-1:0] KEY_NONE      = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_LOW     = 3'd0,
        CFG_Y_LOW     = 3'd1,
        CFG_X_HIGH    = 3'd2,
        CFG_Y_HIGH    = 3'd3,
        CFG_THRESHOLD = 3'd4
    } cfg_index_t;

    // rows picked by x, columns by y
    localparam logic [KEY_W-1:0] KEY_CHARS [KEY_DIM][KEY_DIM] = '{
        '{8'h31, 8'h32, 8'h33, 8'h41},   // 1 2 3 A
        '{8'h34, 8'h35, 8'h36, 8'h42},   // 4 5 6 B
        '{8'h37, 8'h38, 8'h39, 8'h43},   // 7 8 9 C
        '{8'h2A, 8'h30, 8'h23, 8'h44}    // * 0 # D
    };

    typedef struct packed {
        logic             neg;
        logic [RAW_W-1:0] mag;
    } smag_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        smag_t            diff_x;
        smag_t            diff_y;
        smag_t            span_x;
        smag_t            span_y;
    } pre_word_t;

    typedef struct packed {
        logic [5:0]       pad;
        logic             span_error;
        logic [KEY_W-1:0] key_code;
        logic [PCT_W-1:0] y_percent;
        logic [PCT_W-1:0] x_percent;
        logic             pressed;
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] raw_x;
    } result_t;

    // a - b as sign and magnitude
    function automatic smag_t diff_smag(logic [RAW_W-1:0] a, logic [RAW_W-1:0] b);
        logic [RAW_W:0] d;
        logic [RAW_W:0] n;
        smag_t          r;
        d     = {1'b0, a} - {1'b0, b};
        n     = ~d + 1'b1;
        r.neg = d[RAW_W];
        r.mag = d[RAW_W] ? n[RAW_W-1:0] : d[RAW_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/touch_keypad_decoder.sv =====
// Touch keypad decoder.
// Input stream: one word per measurement, two converter samples per axis.
// Output stream: one word per measurement with raw readings, pressed flag,
// calibrated percentages (saturated), keypad character and span error.
// Calibration corners and touch threshold are written through the cfg port
// (cfg_we, cfg_index, cfg_wdata); the user must write them only while no
// word is in flight, as the block does not enforce it. An accepted word
// passes the pre, scale, divider and output registers before m_tvalid.
// Throughput: one word per cycle while m_tready is high. The percent
// division is a restoring divider cut into stages of four quotient bits
// each, and its bit count sets the pipeline depth.
// Reset clears all stage valid bits and loads the calibration defaults
// (low corners 0, high corners 255, threshold 10).
// When m_tready is low the output word holds; earlier stages keep filling
// empty slots, so s_tready drops only once every stage holds a word.
module touch_keypad_decoder
    import tkd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int PERCENT_SCALE = PERCENT_SCALE_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // x_sample_a, x_sample_b, y_sample_a, y_sample_b
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // raw_x, raw_y, pressed, x_percent, y_percent, key_code, span_error
    output logic [OUT_W-1:0]                      m_tdata,
    input  logic                                  cfg_we,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_W-1:0]                      cfg_wdata
);

    localparam int SUM_EXT_W  = SAMPLE_BITS + 1 + RAW_W;
    localparam int PS_W       = $clog2(PERCENT_SCALE + 1);
    localparam int NUM_W      = RAW_W + PS_W;
    localparam int BIT_STEP   = 4;
    localparam int DIV_STAGES = (NUM_W + BIT_STEP - 1) / BIT_STEP;
    localparam int N_STAGES   = DIV_STAGES + 3;

    localparam logic [NUM_W-1:0] PS_VAL   = NUM_W'(PERCENT_SCALE);
    localparam logic [NUM_W-1:0] POS_CLIP = NUM_W'(127);
    localparam logic [NUM_W-1:0] NEG_CLIP = NUM_W'(128);

    typedef struct packed {
        logic [NUM_W-1:0] acc;
        logic [RAW_W-1:0] rem;
        logic [RAW_W-1:0] dvs;
        logic             neg;
        logic             zero;
    } axis_div_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        axis_div_t        ax;
        axis_div_t        ay;
    } div_word_t;

    logic [CFG_W-1:0] cal_x_low_reg, cal_y_low_reg, cal_x_high_reg, cal_y_high_reg;
    logic [CFG_W-1:0] threshold_reg;

    logic [N_STAGES-1:0] valid_reg, valid_next, adv;

    pre_word_t pre_reg, pre_next;
    div_word_t div_reg [DIV_STAGES+1];
    div_word_t div_next [DIV_STAGES+1];
    result_t   out_reg, out_next;

    // restoring division, BIT_STEP quotient bits per stage
    function automatic axis_div_t div_step(axis_div_t a, int first_bit);
        axis_div_t      r;
        logic [RAW_W:0] trial;
        logic [RAW_W:0] diff;
        r = a;
        for (int j = 0; j < BIT_STEP; j++) begin
            if (first_bit + j < NUM_W) begin
                trial = {r.rem, r.acc[NUM_W-1]};
                diff  = trial - {1'b0, r.dvs};
                if (trial >= {1'b0, r.dvs}) begin
                    r.rem = diff[RAW_W-1:0];
                    r.acc = {r.acc[NUM_W-2:0], 1'b1};
                end else begin
                    r.rem = trial[RAW_W-1:0];
                    r.acc = {r.acc[NUM_W-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    function automatic axis_div_t div_load(smag_t diff, smag_t span);
        axis_div_t r;
        r.acc  = NUM_W'(diff.mag) * PS_VAL;
        r.rem  = '0;
        r.dvs  = span.mag;
        r.neg  = diff.neg ^ span.neg;
        r.zero = (span.mag == '0);
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] sat_pct(axis_div_t a);
        logic [NUM_W-1:0] neg_q;
        logic [PCT_W-1:0] r;
        neg_q = ~a.acc + 1'b1;
        if (a.zero) begin
            r = '0;
        end else if (a.neg) begin
            r = (a.acc > NEG_CLIP) ? PCT_NEG_LIMIT : neg_q[PCT_W-1:0];
        end else begin
            r = (a.acc > POS_CLIP) ? PCT_POS_LIMIT : a.acc[PCT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic in_range(axis_div_t a);
        return !a.zero && !a.neg && (a.acc != '0) && (a.acc < PS_VAL);
    endfunction

    function automatic logic [1:0] key_index(logic [NUM_W-1:0] q, int step);
        logic [1:0] r;
        if (q >= NUM_W'(3 * step)) begin
            r = 2'd3;
        end else if (q >= NUM_W'(2 * step)) begin
            r = 2'd2;
        end else if (q >= NUM_W'(step)) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_x_low_reg  <= CAL_LOW_RST;
            cal_y_low_reg  <= CAL_LOW_RST;
            cal_x_high_reg <= CAL_HIGH_RST;
            cal_y_high_reg <= CAL_HIGH_RST;
            threshold_reg  <= THRESHOLD_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_X_LOW:     cal_x_low_reg  <= cfg_wdata;
                CFG_Y_LOW:     cal_y_low_reg  <= cfg_wdata;
                CFG_X_HIGH:    cal_x_high_reg <= cfg_wdata;
                CFG_Y_HIGH:    cal_y_high_reg <= cfg_wdata;
                CFG_THRESHOLD: threshold_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when it is empty or its word moves on
    always_comb begin
        adv[N_STAGES-1] = !valid_reg[N_STAGES-1] || m_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < N_STAGES; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[N_STAGES-1];
    assign m_tdata  = out_reg;

    // stage 0: raw readings, offsets and spans
    always_comb begin
        logic [SUM_EXT_W-1:0] sum_x;
        logic [SUM_EXT_W-1:0] sum_y;
        sum_x = SUM_EXT_W'(s_tdata[SAMPLE_BITS-1:0])
              + SUM_EXT_W'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        sum_y = SUM_EXT_W'(s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS])
              + SUM_EXT_W'(s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS]);
        pre_next.raw_x  = sum_x[RAW_SHIFT+RAW_W-1:RAW_SHIFT];
        pre_next.raw_y  = sum_y[RAW_SHIFT+RAW_W-1:RAW_SHIFT];
        pre_next.diff_x = diff_smag(pre_next.raw_x, cal_x_low_reg);
        pre_next.diff_y = diff_smag(pre_next.raw_y, cal_y_low_reg);
        pre_next.span_x = diff_smag(cal_x_high_reg, cal_x_low_reg);
        pre_next.span_y = diff_smag(cal_y_high_reg, cal_y_low_reg);
    end

    // stage 1: scale, then the divider stages
    always_comb begin
        div_next[0].raw_x = pre_reg.raw_x;
        div_next[0].raw_y = pre_reg.raw_y;
        div_next[0].ax    = div_load(pre_reg.diff_x, pre_reg.span_x);
        div_next[0].ay    = div_load(pre_reg.diff_y, pre_reg.span_y);
        for (int g = 1; g <= DIV_STAGES; g++) begin
            div_next[g].raw_x = div_reg[g-1].raw_x;
            div_next[g].raw_y = div_reg[g-1].raw_y;
            div_next[g].ax    = div_step(div_reg[g-1].ax, (g - 1) * BIT_STEP);
            div_next[g].ay    = div_step(div_reg[g-1].ay, (g - 1) * BIT_STEP);
        end
    end

    // last stage: saturation, range check, key lookup
    always_comb begin
        div_word_t  w;
        logic [1:0] row;
        logic [1:0] col;
        w   = div_reg[DIV_STAGES];
        row = key_index(w.ax.acc, KEY_ROW_STEP);
        col = key_index(w.ay.acc, KEY_COL_STEP);
        out_next            = '0;
        out_next.raw_x      = w.raw_x;
        out_next.raw_y      = w.raw_y;
        out_next.pressed    = (w.raw_x >= threshold_reg) && (w.raw_y >= threshold_reg);
        out_next.x_percent  = sat_pct(w.ax);
        out_next.y_percent  = sat_pct(w.ay);
        out_next.key_code   = (in_range(w.ax) && in_range(w.ay)) ? KEY_CHARS[row][col]
                                                                 : KEY_NONE;
        out_next.span_error = w.ax.zero || w.ay.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
        if (adv[0]) begin
            pre_reg <= pre_next;
        end
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (adv[k+1]) begin
                div_reg[k] <= div_next[k];
            end
        end
        if (adv[N_STAGES-1]) begin
            out_reg <= out_next;
        end
    end

    a_error_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.span_error) |-> (out_reg.key_code == KEY_NONE))
        else $error("key reported with a zero calibration span");

    a_key_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.key_code != KEY_NONE) |->
            ($signed(out_reg.x_percent) > 0 && $signed(out_reg.y_percent) > 0))
        else $error("key reported outside the pad");

    a_pressed_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.pressed) |->
            (out_reg.raw_x >= threshold_reg && out_reg.raw_y >= threshold_reg))
        else $error("pressed set below threshold");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && valid_reg == '1))
        else $error("input stalled while the pipeline has room");

endmodule

// ===== sim/tb_touch_keypad_decoder.sv =====
module tb_touch_keypad_decoder;
    import tkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
    localparam int PERCENT_SCALE  = PERCENT_SCALE_DEF;
    localparam int IN_W           = ((4*SAMPLE_W+7)/8)*8;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 250;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    // x_sample_a in the lowest bits, y_sample_b in the highest
    typedef struct packed {
        logic [SAMPLE_W-1:0] y_sample_b;
        logic [SAMPLE_W-1:0] y_sample_a;
        logic [SAMPLE_W-1:0] x_sample_b;
        logic [SAMPLE_W-1:0] x_sample_a;
    } measurement_t;

    class keypad_scoreboard;
        result_t    pending_results[$];
        logic [7:0] cal_x_low;
        logic [7:0] cal_y_low;
        logic [7:0] cal_x_high;
        logic [7:0] cal_y_high;
        logic [7:0] touch_threshold;
        int         mismatches;

        function new();
            cal_x_low       = CAL_LOW_RST;
            cal_y_low       = CAL_LOW_RST;
            cal_x_high      = CAL_HIGH_RST;
            cal_y_high      = CAL_HIGH_RST;
            touch_threshold = THRESHOLD_RST;
            mismatches      = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] value);
            case (idx)
                CFG_X_LOW:     cal_x_low = value;
                CFG_Y_LOW:     cal_y_low = value;
                CFG_X_HIGH:    cal_x_high = value;
                CFG_Y_HIGH:    cal_y_high = value;
                CFG_THRESHOLD: touch_threshold = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] clamp_percent(int pct);
            int v;
            v = pct;
            if (v > 127) v = 127;
            if (v < -128) v = -128;
            return v[7:0];
        endfunction

        function result_t decode_measurement(measurement_t m);
            result_t r;
            int      rx;
            int      ry;
            int      span_x;
            int      span_y;
            int      px;
            int      py;
            int      row;
            int      col;
            rx     = ((int'(m.x_sample_a) + int'(m.x_sample_b)) >> RAW_SHIFT) & 8'hFF;
            ry     = ((int'(m.y_sample_a) + int'(m.y_sample_b)) >> RAW_SHIFT) & 8'hFF;
            span_x = int'(cal_x_high) - int'(cal_x_low);
            span_y = int'(cal_y_high) - int'(cal_y_low);
            px     = (span_x == 0) ? 0
                   : ((rx - int'(cal_x_low)) * PERCENT_SCALE) / span_x;
            py     = (span_y == 0) ? 0
                   : ((ry - int'(cal_y_low)) * PERCENT_SCALE) / span_y;
            r            = '0;
            r.raw_x      = rx[7:0];
            r.raw_y      = ry[7:0];
            r.pressed    = (rx >= int'(touch_threshold)) && (ry >= int'(touch_threshold));
            r.x_percent  = clamp_percent(px);
            r.y_percent  = clamp_percent(py);
            r.span_error = (span_x == 0) || (span_y == 0);
            r.key_code   = KEY_NONE;
            // range check on the unclamped percentages
            if (!r.span_error && px > 0 && px < PERCENT_SCALE &&
                py > 0 && py < PERCENT_SCALE) begin
                row = px / KEY_ROW_STEP;
                col = py / KEY_COL_STEP;
                if (row > KEY_DIM-1) row = KEY_DIM-1;
                if (col > KEY_DIM-1) col = KEY_DIM-1;
                r.key_code = KEY_CHARS[row][col];
            end
            return r;
        endfunction

        function void note_measurement(measurement_t m);
            pending_results.push_back(decode_measurement(m));
        endfunction

        function void check_decoded(result_t got);
            result_t exp_r;
            logic    bad;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: %h", got);
                return;
            end
            exp_r = pending_results.pop_front();
            bad = (got.raw_x !== exp_r.raw_x) || (got.raw_y !== exp_r.raw_y) ||
                  (got.pressed !== exp_r.pressed) ||
                  (got.x_percent !== exp_r.x_percent) ||
                  (got.y_percent !== exp_r.y_percent) ||
                  (got.key_code !== exp_r.key_code) ||
                  (got.span_error !== exp_r.span_error);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display({"mismatch expected: raw_x=%0d raw_y=%0d pressed=%0b",
                              " x_pct=%0d y_pct=%0d key=%h err=%0b"},
                             exp_r.raw_x, exp_r.raw_y, exp_r.pressed,
                             $signed(exp_r.x_percent), $signed(exp_r.y_percent),
                             exp_r.key_code, exp_r.span_error);
                    $display({"         actual:   raw_x=%0d raw_y=%0d pressed=%0b",
                              " x_pct=%0d y_pct=%0d key=%h err=%0b"},
                             got.raw_x, got.raw_y, got.pressed,
                             $signed(got.x_percent), $signed(got.y_percent),
                             got.key_code, got.span_error);
                end
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we    = 1'b0;
    cfg_index_t           cfg_index = CFG_X_LOW;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    keypad_scoreboard     sb;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   quiet_cycles = 0;

    touch_keypad_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_decoded(result_t'(m_tdata));
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** touch_keypad_decoder: FAILED **");
            $finish;
        end
    end

    function automatic measurement_t samples_for(int raw_x, int raw_y);
        measurement_t m;
        int           sx;
        int           sy;
        int           a;
        sx = raw_x * 8 + $urandom_range(0, 7);
        sy = raw_y * 8 + $urandom_range(0, 7);
        if (sx > 2 * SAMPLE_MAX) sx = 2 * SAMPLE_MAX;
        if (sy > 2 * SAMPLE_MAX) sy = 2 * SAMPLE_MAX;
        a = $urandom_range((sx > SAMPLE_MAX) ? sx - SAMPLE_MAX : 0,
                           (sx < SAMPLE_MAX) ? sx : SAMPLE_MAX);
        m.x_sample_a = SAMPLE_W'(a);
        m.x_sample_b = SAMPLE_W'(sx - a);
        a = $urandom_range((sy > SAMPLE_MAX) ? sy - SAMPLE_MAX : 0,
                           (sy < SAMPLE_MAX) ? sy : SAMPLE_MAX);
        m.y_sample_a = SAMPLE_W'(a);
        m.y_sample_b = SAMPLE_W'(sy - a);
        return m;
    endfunction

    task automatic send_word(input measurement_t m);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        do @(posedge aclk); while (!s_tready);
        sb.note_measurement(m);
    endtask

    task automatic load_reg(input cfg_index_t idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_config(input logic [7:0] xl, input logic [7:0] yl,
                              input logic [7:0] xh, input logic [7:0] yh,
                              input logic [7:0] thr);
        s_tvalid <= 1'b0;
        load_reg(CFG_X_LOW, xl);
        load_reg(CFG_Y_LOW, yl);
        load_reg(CFG_X_HIGH, xh);
        load_reg(CFG_Y_HIGH, yh);
        load_reg(CFG_THRESHOLD, thr);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int           row_raw [4];
        int           col_raw [4];
        int           lo_x;
        int           hi_x;
        int           lo_y;
        int           hi_y;
        int           r;
        logic [63:0]  noise;
        measurement_t m;
        logic [7:0]   base;

        row_raw = '{31, 95, 159, 223};
        col_raw = '{41, 125, 210, 253};
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset calibration: every keypad cell, pad edges, bit patterns
        for (int i = 0; i < KEY_DIM; i++)
            for (int j = 0; j < KEY_DIM; j++)
                send_word(samples_for(row_raw[i], col_raw[j]));
        send_word('0);
        send_word('1);
        m.x_sample_a = 10'h2AA;
        m.x_sample_b = 10'h155;
        m.y_sample_a = 10'h155;
        m.y_sample_b = 10'h2AA;
        send_word(m);
        wait_drained();

        // zero x span, reversed y span, top threshold
        set_config(8'd100, 8'd255, 8'd100, 8'd0, 8'd255);
        send_word('1);
        send_word(samples_for(150, 60));
        wait_drained();

        // one-step spans push the percentages far out of range
        set_config(8'd0, 8'd0, 8'd1, 8'd1, 8'd0);
        send_word(samples_for(255, 255));
        send_word(samples_for(0, 1));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_config(CAL_LOW_RST, CAL_LOW_RST, CAL_HIGH_RST, CAL_HIGH_RST,
                              THRESHOLD_RST);
                1: set_config(8'd255, 8'd255, 8'd0, 8'd0, 8'd255);
                2: begin
                    base = 8'($urandom_range(0, 255));
                    set_config(base, 8'd0, base, 8'd255, 8'd0);
                end
                3: begin
                    base = 8'($urandom_range(0, 254));
                    set_config(base, 8'($urandom_range(0, 255)), base + 8'd1,
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            case (p / 2)
                0: begin send_idle_pct = 34; recv_stall_pct = 83; end
                1: begin send_idle_pct = 83; recv_stall_pct = 34; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            lo_x = (sb.cal_x_low < sb.cal_x_high) ? int'(sb.cal_x_low) : int'(sb.cal_x_high);
            hi_x = (sb.cal_x_low < sb.cal_x_high) ? int'(sb.cal_x_high) : int'(sb.cal_x_low);
            lo_y = (sb.cal_y_low < sb.cal_y_high) ? int'(sb.cal_y_low) : int'(sb.cal_y_high);
            hi_y = (sb.cal_y_low < sb.cal_y_high) ? int'(sb.cal_y_high) : int'(sb.cal_y_low);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // inside the calibrated window
                    send_word(samples_for($urandom_range(lo_x, hi_x),
                                          $urandom_range(lo_y, hi_y)));
                end else begin
                    noise = {$urandom(), $urandom()};
                    m = noise[IN_W-1:0];
                    send_word(m);
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("** touch_keypad_decoder: PASSED **");
        else
            $display("** touch_keypad_decoder: FAILED **");
        $finish;
    end

endmodule
